// File: rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Constants for the range-reduced Taylor sine unit: reduction constants in
// unsigned Q.31, datapath widths and the default series length.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int DEFAULT_TERMS = 8;

  // reduced magnitude path, Q.31 with room for 8.0
  localparam int MAG_W = 35;
  // reduced angle, Q.31 in [0, pi/2]
  localparam int X_W = 32;
  // x squared, Q.31
  localparam int X2_W = 33;
  // rounded series product before the factorial divide
  localparam int Y_W = 34;
  // reciprocal for the factorial divide
  localparam int RECIP_W = 32;
  localparam int RECIP_SHIFT = 34;
  // signed running sum
  localparam int SUM_W = 35;
  // result magnitude, Q1.30 up to 1.0
  localparam int RES_W = 31;

  localparam logic [MAG_W-1:0] Q31_TWO_PI  = 35'd13493037705;
  localparam logic [MAG_W-1:0] Q31_PI      = 35'd6746518852;
  localparam logic [MAG_W-1:0] Q31_HALF_PI = 35'd3373259426;
  localparam logic [RES_W-1:0] Q30_ONE     = 31'd1073741824;

endpackage

`default_nettype wire

// File: rtl/sine_range_reduced_taylor_unit.sv
// ----------------------------------------------------------------------------
// sine_range_reduced_taylor_unit
// Sine of a Q3.28 angle in radians as Q2.30, by quadrant reduction and a
// fixed-length odd Taylor series, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one angle per clock and returns its sine at the end of the pipeline.
// The pipeline length is set by the series: each term after the first passes
// through its own three-stage unit (multiply by x squared, multiply by the
// reciprocal of the factorial step, correct and sum), in addition to four
// reduction stages, the squaring stages and three output stages. done is high
// for exactly one cycle with each result and cannot be held off; busy is high
// only during reset.
`default_nettype none

module sine_range_reduced_taylor_unit #(
  parameter int TERMS = srt_pkg::DEFAULT_TERMS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] angle,
  output logic             done,
  output logic signed [31:0] sine_value
);

  localparam int MAG_W   = srt_pkg::MAG_W;
  localparam int X_W     = srt_pkg::X_W;
  localparam int X2_W    = srt_pkg::X2_W;
  localparam int Y_W     = srt_pkg::Y_W;
  localparam int RECIP_W = srt_pkg::RECIP_W;
  localparam int SUM_W   = srt_pkg::SUM_W;
  localparam int RES_W   = srt_pkg::RES_W;
  localparam int PROD_W  = X_W + X2_W;
  localparam int RPROD_W = Y_W + RECIP_W;
  localparam int LAST    = TERMS - 1;
  localparam int LAT     = 3 * TERMS + 6;

  assign busy = rst;

  // --------------------------------------------------------------------------
  // Reduction
  // --------------------------------------------------------------------------
  logic             s0_valid, s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic             s0_neg, s1_neg, s2_neg, s3_neg, s4_neg, s5_neg;
  logic [MAG_W-1:0] s0_mag, s1_mag, s2_mag;
  logic [X_W-1:0]   s3_x, s4_x, s5_x;
  logic [2*X_W-1:0] s4_sq;
  logic [X2_W-1:0]  s5_x2;
  logic [31:0]      abs_angle;

  assign abs_angle = angle[31] ? 32'(-angle) : 32'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s0_valid <= start;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_neg <= angle[31];
    s0_mag <= {abs_angle, 3'b000};

    s1_neg <= s0_neg;
    s1_mag <= (s0_mag >= srt_pkg::Q31_TWO_PI) ? s0_mag - srt_pkg::Q31_TWO_PI : s0_mag;

    if (s1_mag >= srt_pkg::Q31_PI) begin
      s2_neg <= !s1_neg;
      s2_mag <= s1_mag - srt_pkg::Q31_PI;
    end else begin
      s2_neg <= s1_neg;
      s2_mag <= s1_mag;
    end

    s3_neg <= s2_neg;
    s3_x   <= (s2_mag >= srt_pkg::Q31_HALF_PI) ? X_W'(srt_pkg::Q31_PI - s2_mag)
                                               : X_W'(s2_mag);

    s4_neg <= s3_neg;
    s4_x   <= s3_x;
    s4_sq  <= (2*X_W)'(s3_x) * (2*X_W)'(s3_x);

    s5_neg <= s4_neg;
    s5_x   <= s4_x;
    s5_x2  <= X2_W'(((2*X_W+1)'(s4_sq) + (2*X_W+1)'(33'd1 << 30)) >> 31);
  end

  // --------------------------------------------------------------------------
  // Series chain: link 0 is the first term x with an empty sum
  // --------------------------------------------------------------------------
  wire                    t_valid [TERMS];
  wire                    t_neg   [TERMS];
  wire [X2_W-1:0]         t_x2    [TERMS];
  wire [X_W-1:0]          t_term  [TERMS];
  wire signed [SUM_W-1:0] t_sum   [TERMS];

  assign t_valid[0] = s5_valid;
  assign t_neg[0]   = s5_neg;
  assign t_x2[0]    = s5_x2;
  assign t_term[0]  = s5_x;
  assign t_sum[0]   = '0;

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    localparam int DIV = (2 * k) * (2 * k + 1);
    localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << srt_pkg::RECIP_SHIFT) / 64'(DIV));

    logic                    a_valid, b_valid, c_valid;
    logic                    a_neg, b_neg, c_neg;
    logic [X2_W-1:0]         a_x2, b_x2, c_x2;
    logic signed [SUM_W-1:0] a_sum, b_sum, c_sum;
    logic [PROD_W-1:0]       a_prod;
    logic [Y_W-1:0]          b_y;
    logic [RPROD_W-1:0]      b_rprod;
    logic [X_W-1:0]          c_term;
    logic signed [SUM_W-1:0] sum_next;
    logic [Y_W-1:0]          y_next;
    logic [X_W-1:0]          q0;
    logic [Y_W-1:0]          rem;

    always_comb begin
      if ((k - 1) % 2 == 1) begin
        sum_next = t_sum[k-1] - SUM_W'(t_term[k-1]);
      end else begin
        sum_next = t_sum[k-1] + SUM_W'(t_term[k-1]);
      end
    end

    assign y_next = Y_W'((a_prod + PROD_W'(33'd1 << 30)) >> 31);
    assign q0     = X_W'(b_rprod >> srt_pkg::RECIP_SHIFT);
    assign rem    = b_y - Y_W'(Y_W'(q0) * Y_W'(DIV));

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid <= 1'b0;
        b_valid <= 1'b0;
        c_valid <= 1'b0;
      end else begin
        a_valid <= t_valid[k-1];
        b_valid <= a_valid;
        c_valid <= b_valid;
      end
    end

    always_ff @(posedge clk) begin
      a_neg  <= t_neg[k-1];
      a_x2   <= t_x2[k-1];
      a_sum  <= sum_next;
      a_prod <= PROD_W'(t_term[k-1]) * PROD_W'(t_x2[k-1]);

      b_neg   <= a_neg;
      b_x2    <= a_x2;
      b_sum   <= a_sum;
      b_y     <= y_next;
      b_rprod <= RPROD_W'(y_next) * RPROD_W'(RECIP);

      c_neg  <= b_neg;
      c_x2   <= b_x2;
      c_sum  <= b_sum;
      c_term <= (rem >= Y_W'(DIV)) ? q0 + X_W'(1) : q0;
    end

    assign t_valid[k] = c_valid;
    assign t_neg[k]   = c_neg;
    assign t_x2[k]    = c_x2;
    assign t_term[k]  = c_term;
    assign t_sum[k]   = c_sum;
  end

  // --------------------------------------------------------------------------
  // Final sum, rounding, saturation and sign
  // --------------------------------------------------------------------------
  logic                    f_valid, g_valid;
  logic                    f_neg, g_neg;
  logic signed [SUM_W-1:0] f_sum;
  logic signed [SUM_W-1:0] f_sum_next;
  logic [RES_W-1:0]        g_mag;
  logic [SUM_W-1:0]        rounded;

  always_comb begin
    if (LAST % 2 == 1) begin
      f_sum_next = t_sum[LAST] - SUM_W'(t_term[LAST]);
    end else begin
      f_sum_next = t_sum[LAST] + SUM_W'(t_term[LAST]);
    end
  end

  assign rounded = (SUM_W'(f_sum) + SUM_W'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      f_valid <= t_valid[LAST];
      g_valid <= f_valid;
      done    <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_neg <= t_neg[LAST];
    f_sum <= f_sum_next;

    g_neg <= f_neg;
    if (f_sum[SUM_W-1]) begin
      g_mag <= '0;
    end else if (rounded > SUM_W'(srt_pkg::Q30_ONE)) begin
      g_mag <= srt_pkg::Q30_ONE;
    end else begin
      g_mag <= RES_W'(rounded);
    end

    sine_value <= g_neg ? -32'(g_mag) : 32'(g_mag);
  end

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item gave no result after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching accepted item");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (sine_value <= 32'sd1073741824 && sine_value >= -32'sd1073741824))
    else $error("result outside [-1.0, 1.0]");

  a_zero : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && angle == 32'sd0) |-> ##LAT (sine_value == 32'sd0))
    else $error("sine of zero is not zero");

  a_first_quadrant : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !angle[31] && angle < 32'sd421657428)
      |-> ##LAT !sine_value[31])
    else $error("negative sine for an angle in the first quadrant");
`endif

endmodule

`default_nettype wire
